@@ design/csvv_pkg.sv @@
// ----------------------------------------------------------------------------
// CSV record validator package
// Shared constants, status codes, result types and byte helpers.
// ----------------------------------------------------------------------------
package csvv_pkg;

  // Width of the saturating line and record counters.
  localparam int CountW = 16;
  localparam int DnaW   = 12;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_LO_N  = 8'h6e;
  localparam logic [7:0] CHAR_UP_N  = 8'h4e;

  localparam logic [DnaW-1:0] MIN_DNA_RESET = 12'd20;
  localparam logic [2:0]      FIELDS_EXPECTED = 3'd3;

  typedef enum logic [3:0] {
    ST_ACCEPTED    = 4'd0,
    ST_EMPTY_SKIP  = 4'd1,
    ST_HEADER_SKIP = 4'd2,
    ST_FIELD_COUNT = 4'd3,
    ST_EMPTY_NAME  = 4'd4,
    ST_EMPTY_ID    = 4'd5,
    ST_BAD_DNA     = 4'd6,
    ST_SHORT_DNA   = 4'd7,
    ST_NO_RECORDS  = 4'd8,
    ST_FILE_OK     = 4'd9,
    ST_ABORTED     = 4'd10
  } status_t;

  // One result beat.
  typedef struct packed {
    status_t     status;
    logic [15:0] line_number;
    logic [2:0]  field_count;
    logic [15:0] record_count;
    logic        last;
  } res_t;

  // Results produced by one processed input beat (zero, one or two).
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  // Whitespace as the C library defines it: tab through carriage return, space.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // Characters that follow the leading n of the header keyword.
  function automatic logic [7:0] header_tail(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd1:    ch = 8'h6f;
      3'd2:    ch = 8'h6d;
      3'd3:    ch = 8'h62;
      3'd4:    ch = 8'h72;
      3'd5:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ design/csvv_if.sv @@
// ----------------------------------------------------------------------------
// CSV record validator channels
// Valid/ready channels for input bytes, results and the configuration write.
// ----------------------------------------------------------------------------
interface csvv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, data_byte, end_of_input, input ready);
  modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

interface csvv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] line_number;
  logic [2:0]  field_count;
  logic [15:0] record_count;
  logic        last;

  modport source (output valid, status, line_number, field_count, record_count, last,
                  input ready);
  modport sink   (input valid, status, line_number, field_count, record_count, last,
                  output ready);
endinterface

interface csvv_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] min_dna_length;

  modport source (output valid, min_dna_length, input ready);
  modport sink   (input valid, min_dna_length, output ready);
endinterface

@@ design/csvv_parser.sv @@
// ----------------------------------------------------------------------------
// CSV record validator parser
// Registers each input beat, updates the per-line and per-file state and
// forms the line and summary results in one pass.
// ----------------------------------------------------------------------------
module csvv_parser
  import csvv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat_valid,
  output logic             beat_ready,
  input  logic [7:0]       data_byte,
  input  logic             end_of_input,
  input  logic             cfg_valid,
  input  logic [DnaW-1:0]  cfg_min_len,
  input  logic             q_room,
  output push_t            push
);

  // Input holding register.
  logic       hold_valid_r;
  logic [7:0] byte_r;
  logic       eoi_r;
  logic       work;

  assign work       = hold_valid_r && q_room;
  assign beat_ready = !hold_valid_r || q_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (beat_ready) begin
      hold_valid_r <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_ready && beat_valid) begin
      byte_r <= data_byte;
      eoi_r  <= end_of_input;
    end
  end

  // Minimum base count register.
  logic [DnaW-1:0] min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_DNA_RESET;
    end else if (cfg_valid) begin
      min_len_r <= cfg_min_len;
    end
  end

  // Line and file state.
  logic              in_quotes_r, in_quotes_nxt;
  logic [1:0]        field_pos_r, field_pos_nxt;
  logic              has_bytes_r, has_bytes_nxt;
  logic              has_nonspace_r, has_nonspace_nxt;
  logic              name_ok_r, name_ok_nxt;
  logic              id_ok_r, id_ok_nxt;
  logic              dna_started_r, dna_started_nxt;
  logic              dna_space_r, dna_space_nxt;
  logic              dna_bad_r, dna_bad_nxt;
  logic [DnaW-1:0]   dna_len_r, dna_len_nxt;
  logic [2:0]        hdr_prog_r, hdr_prog_nxt;
  logic              hdr_seen_r, hdr_seen_nxt;
  logic [CountW-1:0] line_cnt_r, line_cnt_nxt;
  logic [CountW-1:0] rec_cnt_r, rec_cnt_nxt;
  logic              err_r, err_nxt;

  // Line result, formed from the state before the ending beat.
  logic [CountW-1:0] line_no;
  logic [2:0]        line_fc;
  status_t           line_st;
  logic              line_err;
  logic [CountW-1:0] line_rec;
  res_t              line_res;

  always_comb begin
    line_no = (line_cnt_r == '1) ? line_cnt_r : line_cnt_r + 1'b1;
    line_fc = {1'b0, field_pos_r} + 3'd1;
    priority if (err_r) begin
      line_st = ST_ABORTED;
    end else if (!has_nonspace_r) begin
      line_st = ST_EMPTY_SKIP;
    end else if ((line_no == CountW'(1)) && hdr_seen_r) begin
      line_st = ST_HEADER_SKIP;
    end else if (line_fc != FIELDS_EXPECTED) begin
      line_st = ST_FIELD_COUNT;
    end else if (!name_ok_r) begin
      line_st = ST_EMPTY_NAME;
    end else if (!id_ok_r) begin
      line_st = ST_EMPTY_ID;
    end else if (dna_bad_r || !dna_started_r) begin
      line_st = ST_BAD_DNA;
    end else if (dna_len_r < min_len_r) begin
      line_st = ST_SHORT_DNA;
    end else begin
      line_st = ST_ACCEPTED;
    end
    line_err = err_r || (line_st == ST_FIELD_COUNT) || (line_st == ST_EMPTY_NAME) ||
               (line_st == ST_EMPTY_ID) || (line_st == ST_BAD_DNA) ||
               (line_st == ST_SHORT_DNA);
    line_rec = ((line_st == ST_ACCEPTED) && (rec_cnt_r != '1)) ? rec_cnt_r + 1'b1
                                                                : rec_cnt_r;
    line_res.status       = line_st;
    line_res.line_number  = 16'(line_no);
    line_res.field_count  = line_fc;
    line_res.record_count = 16'(line_rec);
    line_res.last         = !eoi_r;
  end

  // Summary result, after any pending line has been closed.
  logic [CountW-1:0] sum_line;
  logic [CountW-1:0] sum_rec;
  logic              sum_err;
  res_t              sum_res;

  always_comb begin
    sum_line = has_bytes_r ? line_no  : line_cnt_r;
    sum_rec  = has_bytes_r ? line_rec : rec_cnt_r;
    sum_err  = has_bytes_r ? line_err : err_r;
    priority if (sum_err) begin
      sum_res.status = ST_ABORTED;
    end else if (sum_rec == '0) begin
      sum_res.status = ST_NO_RECORDS;
    end else begin
      sum_res.status = ST_FILE_OK;
    end
    sum_res.line_number  = 16'(sum_line);
    sum_res.field_count  = 3'd0;
    sum_res.record_count = 16'(sum_rec);
    sum_res.last         = 1'b1;
  end

  // Byte classification.
  logic is_space;
  logic is_base;
  logic is_nl;

  assign is_space = is_ws(byte_r);
  assign is_base  = (byte_r == CHAR_A) || (byte_r == CHAR_T) ||
                    (byte_r == CHAR_C) || (byte_r == CHAR_G);
  assign is_nl    = (byte_r == CHAR_NL);

  // Next state and result pushes.
  always_comb begin
    in_quotes_nxt    = in_quotes_r;
    field_pos_nxt    = field_pos_r;
    has_bytes_nxt    = has_bytes_r;
    has_nonspace_nxt = has_nonspace_r;
    name_ok_nxt      = name_ok_r;
    id_ok_nxt        = id_ok_r;
    dna_started_nxt  = dna_started_r;
    dna_space_nxt    = dna_space_r;
    dna_bad_nxt      = dna_bad_r;
    dna_len_nxt      = dna_len_r;
    hdr_prog_nxt     = hdr_prog_r;
    hdr_seen_nxt     = hdr_seen_r;
    line_cnt_nxt     = line_cnt_r;
    rec_cnt_nxt      = rec_cnt_r;
    err_nxt          = err_r;
    push.count       = 2'd0;
    push.first       = line_res;
    push.second      = sum_res;

    if (work) begin
      if (eoi_r || is_nl) begin
        // Close the line: every per-line flag returns to its reset value.
        in_quotes_nxt    = 1'b0;
        field_pos_nxt    = 2'd0;
        has_bytes_nxt    = 1'b0;
        has_nonspace_nxt = 1'b0;
        name_ok_nxt      = 1'b0;
        id_ok_nxt        = 1'b0;
        dna_started_nxt  = 1'b0;
        dna_space_nxt    = 1'b0;
        dna_bad_nxt      = 1'b0;
        dna_len_nxt      = '0;
        hdr_prog_nxt     = 3'd0;
        hdr_seen_nxt     = 1'b0;
        if (eoi_r) begin
          line_cnt_nxt = '0;
          rec_cnt_nxt  = '0;
          err_nxt      = 1'b0;
          if (has_bytes_r) begin
            push.count = 2'd2;
          end else begin
            push.count = 2'd1;
            push.first = sum_res;
          end
        end else begin
          line_cnt_nxt = line_no;
          rec_cnt_nxt  = line_rec;
          err_nxt      = line_err;
          push.count   = 2'd1;
        end
      end else begin
        has_bytes_nxt = 1'b1;
        if (!is_space) begin
          has_nonspace_nxt = 1'b1;
        end

        // Header keyword search, case-folded only on the first letter.
        if (!hdr_seen_r) begin
          if ((hdr_prog_r != 3'd0) && (byte_r == header_tail(hdr_prog_r))) begin
            if (hdr_prog_r == 3'd5) begin
              hdr_seen_nxt = 1'b1;
              hdr_prog_nxt = 3'd0;
            end else begin
              hdr_prog_nxt = hdr_prog_r + 3'd1;
            end
          end else begin
            hdr_prog_nxt = ((byte_r == CHAR_LO_N) || (byte_r == CHAR_UP_N)) ? 3'd1 : 3'd0;
          end
        end

        // Field splitting and per-field checks.
        priority if (byte_r == CHAR_QUOTE) begin
          in_quotes_nxt = !in_quotes_r;
        end else if ((byte_r == CHAR_COMMA) && !in_quotes_r) begin
          if (field_pos_r != 2'd3) begin
            field_pos_nxt = field_pos_r + 2'd1;
          end
        end else if (field_pos_r == 2'd0) begin
          if (!is_space) begin
            name_ok_nxt = 1'b1;
          end
        end else if (field_pos_r == 2'd1) begin
          if (!is_space) begin
            id_ok_nxt = 1'b1;
          end
        end else if (field_pos_r == 2'd2) begin
          if (is_space) begin
            if (dna_started_r) begin
              dna_space_nxt = 1'b1;
            end
          end else begin
            if (dna_space_r || !is_base) begin
              dna_bad_nxt = 1'b1;
            end
            dna_started_nxt = 1'b1;
            if (dna_len_r != '1) begin
              dna_len_nxt = dna_len_r + 1'b1;
            end
          end
        end else begin
          // Fourth and later fields are not checked.
          dna_len_nxt = dna_len_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r    <= 1'b0;
      field_pos_r    <= 2'd0;
      has_bytes_r    <= 1'b0;
      has_nonspace_r <= 1'b0;
      name_ok_r      <= 1'b0;
      id_ok_r        <= 1'b0;
      dna_started_r  <= 1'b0;
      dna_space_r    <= 1'b0;
      dna_bad_r      <= 1'b0;
      dna_len_r      <= '0;
      hdr_prog_r     <= 3'd0;
      hdr_seen_r     <= 1'b0;
      line_cnt_r     <= '0;
      rec_cnt_r      <= '0;
      err_r          <= 1'b0;
    end else begin
      in_quotes_r    <= in_quotes_nxt;
      field_pos_r    <= field_pos_nxt;
      has_bytes_r    <= has_bytes_nxt;
      has_nonspace_r <= has_nonspace_nxt;
      name_ok_r      <= name_ok_nxt;
      id_ok_r        <= id_ok_nxt;
      dna_started_r  <= dna_started_nxt;
      dna_space_r    <= dna_space_nxt;
      dna_bad_r      <= dna_bad_nxt;
      dna_len_r      <= dna_len_nxt;
      hdr_prog_r     <= hdr_prog_nxt;
      hdr_seen_r     <= hdr_seen_nxt;
      line_cnt_r     <= line_cnt_nxt;
      rec_cnt_r      <= rec_cnt_nxt;
      err_r          <= err_nxt;
    end
  end

endmodule

@@ design/csvv_out_queue.sv @@
// ----------------------------------------------------------------------------
// CSV record validator result queue
// Four-entry queue that takes up to two results per cycle and hands out one
// result beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module csvv_out_queue
  import csvv_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  q_room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t       entry_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] fill_r, fill_nxt;
  logic       pop;

  // Room for two more results, so an end-of-file beat never overflows.
  assign q_room    = (fill_r <= 3'd2);
  assign out_valid = (fill_r != 3'd0);
  assign out_res   = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.count;
    rd_ptr_nxt = pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push.count} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      fill_r   <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry writes.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry_r[wr_ptr_r + 2'd1] <= push.second;
    end
  end

endmodule

@@ design/csv_record_validator.sv @@
// ----------------------------------------------------------------------------
// CSV record validator
// Checks a byte stream as three-field comma-separated records, one status
// beat per line and a summary beat at end of file.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one file byte per beat; a beat with end_of_input set closes
//   any unterminated line and yields the file summary. out_bus carries status
//   beats; last marks the final beat caused by one input beat.
//   cfg_bus writes the minimum base count; the user must write it only while
//   the block is idle, which the block does not enforce. It is always ready.
// Path: a line or summary result reaches out_bus through the input register,
//   then the result queue, from an accepted input beat.
// Throughput: one input beat per cycle. An end-of-file beat with a pending
//   line produces two result beats, which drain one per cycle while
//   out_bus.ready is high from the four-entry result queue; the input stalls
//   only when fewer than two queue entries are free.
// Reset: rst_n clears all line and file state and sets the minimum length to
//   20. After each end-of-file beat the file state clears itself as well.
// Stalls: when out_bus.ready is low the queue fills and in_bus.ready drops;
//   no result is lost or repeated.
// ----------------------------------------------------------------------------
module csv_record_validator
  import csvv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  csvv_in_if.sink     in_bus,
  csvv_out_if.source  out_bus,
  csvv_cfg_if.sink    cfg_bus
);

  push_t push;
  logic  q_room;
  res_t  out_res;

  assign cfg_bus.ready = 1'b1;

  // Line parser and checker.
  csvv_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_valid   (in_bus.valid),
    .beat_ready   (in_bus.ready),
    .data_byte    (in_bus.data_byte),
    .end_of_input (in_bus.end_of_input),
    .cfg_valid    (cfg_bus.valid),
    .cfg_min_len  (cfg_bus.min_dna_length),
    .q_room       (q_room),
    .push         (push)
  );

  // Result queue.
  csvv_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_room    (q_room),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_res   (out_res)
  );

  assign out_bus.status       = out_res.status;
  assign out_bus.line_number  = out_res.line_number;
  assign out_bus.field_count  = out_res.field_count;
  assign out_bus.record_count = out_res.record_count;
  assign out_bus.last         = out_res.last;

endmodule
